### rtl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg: shared definitions for the handheld sound channel unit
// Bus function codes, register addresses, reset seeds and result type.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

  // Default parameter values
  localparam int TICK_DIVIDE_DEF = 16;
  localparam int WAVE_STEPS_DEF  = 32;

  // Bus function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // I/O register addresses (low byte)
  localparam logic [7:0] CTRL_BASE = 8'h10;
  localparam logic [7:0] A_NR11    = 8'h11;
  localparam logic [7:0] A_NR13    = 8'h13;
  localparam logic [7:0] A_NR14    = 8'h14;
  localparam logic [7:0] A_NR21    = 8'h16;
  localparam logic [7:0] A_NR23    = 8'h18;
  localparam logic [7:0] A_NR24    = 8'h19;
  localparam logic [7:0] A_NR33    = 8'h1D;
  localparam logic [7:0] A_NR34    = 8'h1E;
  localparam logic [7:0] A_NR41    = 8'h20;
  localparam logic [7:0] A_NR43    = 8'h22;
  localparam logic [7:0] A_NR44    = 8'h23;

  // Address high nibbles of the register window
  localparam logic [3:0] PAGE_CTRL_LO = 4'h1;
  localparam logic [3:0] PAGE_CTRL_HI = 4'h2;
  localparam logic [3:0] PAGE_WAVE    = 4'h3;

  localparam logic [10:0] PERIOD_FLIP = 11'h7FF;
  localparam logic [15:0] NOISE_SEED  = 16'hEA31;
  localparam logic [7:0]  READ_VALUE  = 8'hFF;

  typedef struct packed {
    logic [7:0] read_data;
    logic       is_sample;
    logic       pulse_one_level;
    logic       pulse_two_level;
    logic [3:0] wave_level;
    logic       noise_level;
  } result_t;

  typedef struct packed {
    logic        inverted;
    logic [10:0] threshold;
  } pulse_shape_t;

  // Duty code to compare threshold and polarity
  function automatic pulse_shape_t pulse_shape(input logic [1:0] duty,
                                               input logic [10:0] period);
    pulse_shape_t s;
    unique case (duty)
      2'd0: begin
        s.threshold = period >> 3;
        s.inverted  = 1'b0;
      end
      2'd1: begin
        s.threshold = period >> 2;
        s.inverted  = 1'b0;
      end
      2'd2: begin
        s.threshold = period >> 1;
        s.inverted  = 1'b0;
      end
      default: begin
        s.threshold = period >> 2;
        s.inverted  = 1'b1;
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/handheld_sound_channel_unit.sv
// ----------------------------------------------------------------------------
// handheld_sound_channel_unit: pulse, wave and noise sound channels
// A request's result is registered into the output register, or into the skid
// register while the output stalls.
// Throughput: one request per cycle. A skid register takes one more result
// while the output stalls; further requests then wait until it drains.
// Reset (synchronous, rst high): channel state and register window clear,
// the noise shifter loads its seed, no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module handheld_sound_channel_unit #(
  parameter int TICK_DIVIDE = hsc_pkg::TICK_DIVIDE_DEF,
  parameter int WAVE_STEPS  = hsc_pkg::WAVE_STEPS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // request channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] func,
  input  wire logic [7:0] address,
  input  wire logic [7:0] write_data,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      read_data,
  output logic            is_sample,
  output logic            pulse_one_level,
  output logic            pulse_two_level,
  output logic [3:0]      wave_level,
  output logic            noise_level
);

  localparam int DIV_W = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;
  localparam int POS_W = $clog2(WAVE_STEPS);

  localparam logic [4:0] IDX_NR11 = 5'(hsc_pkg::A_NR11 - hsc_pkg::CTRL_BASE);
  localparam logic [4:0] IDX_NR13 = 5'(hsc_pkg::A_NR13 - hsc_pkg::CTRL_BASE);
  localparam logic [4:0] IDX_NR21 = 5'(hsc_pkg::A_NR21 - hsc_pkg::CTRL_BASE);
  localparam logic [4:0] IDX_NR23 = 5'(hsc_pkg::A_NR23 - hsc_pkg::CTRL_BASE);
  localparam logic [4:0] IDX_NR33 = 5'(hsc_pkg::A_NR33 - hsc_pkg::CTRL_BASE);
  localparam logic [4:0] IDX_NR41 = 5'(hsc_pkg::A_NR41 - hsc_pkg::CTRL_BASE);
  localparam logic [4:0] IDX_NR43 = 5'(hsc_pkg::A_NR43 - hsc_pkg::CTRL_BASE);

  // --------------------------------------------------------------------------
  // Register window: 0x10..0x2F control bytes, 0x30..0x3F wave RAM.
  // Control bytes are read only at fixed places; wave RAM at one pointer.
  // --------------------------------------------------------------------------
  logic [7:0] ctrl_regs [32];
  logic [7:0] wave_ram  [16];

  // Tick prescaler
  logic [DIV_W-1:0] tick_divider, tick_divider_next;

  // Pulse channels
  logic [10:0] pulse_period    [2];
  logic [10:0] pulse_count     [2];
  logic [10:0] pulse_threshold [2];
  logic        pulse_inverted  [2];
  logic        pulse_bit       [2];
  logic        pulse_enabled   [2];
  logic [10:0] pulse_period_next    [2];
  logic [10:0] pulse_count_next     [2];
  logic [10:0] pulse_threshold_next [2];
  logic        pulse_inverted_next  [2];
  logic        pulse_bit_next       [2];
  logic        pulse_enabled_next   [2];

  // Wave channel
  logic [10:0]      wave_period,   wave_period_next;
  logic [10:0]      wave_count,    wave_count_next;
  logic [POS_W-1:0] wave_position, wave_position_next;
  logic [3:0]       wave_sample,   wave_sample_next;
  logic             wave_enabled,  wave_enabled_next;

  // Noise channel
  logic [19:0] noise_period,    noise_period_next;
  logic [19:0] noise_count,     noise_count_next;
  logic [15:0] noise_shifter,   noise_shifter_next;
  logic        noise_bit,       noise_bit_next;
  logic        noise_enabled,   noise_enabled_next;
  logic [15:0] noise_remaining, noise_remaining_next;

  // Output register plus skid register
  hsc_pkg::result_t res_c, out_res, skid_res;
  logic             res_valid_c;
  logic             skid_valid;
  logic             accept;

  // --------------------------------------------------------------------------
  // Handshake: the skid register absorbs one result while the output stalls,
  // so a request is refused only while the skid register is full.
  // --------------------------------------------------------------------------
  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  // Per-channel sources read from the window, and per-channel trigger addresses
  logic [7:0] pulse_duty_reg [2];
  logic [7:0] pulse_lo_reg   [2];
  logic [7:0] trig_addr      [2];

  assign pulse_duty_reg[0] = ctrl_regs[IDX_NR11];
  assign pulse_duty_reg[1] = ctrl_regs[IDX_NR21];
  assign pulse_lo_reg[0]   = ctrl_regs[IDX_NR13];
  assign pulse_lo_reg[1]   = ctrl_regs[IDX_NR23];
  assign trig_addr[0]      = hsc_pkg::A_NR14;
  assign trig_addr[1]      = hsc_pkg::A_NR24;

  // Window decode
  logic       in_ctrl, in_wave;
  logic [4:0] ctrl_idx;

  assign in_ctrl  = (address[7:4] == hsc_pkg::PAGE_CTRL_LO) ||
                    (address[7:4] == hsc_pkg::PAGE_CTRL_HI);
  assign in_wave  = (address[7:4] == hsc_pkg::PAGE_WAVE);
  assign ctrl_idx = 5'(address - hsc_pkg::CTRL_BASE);

  // Wave pointer step and RAM fetch
  logic [POS_W-1:0] wave_pos_inc;
  logic [6:0]       wave_pos_wide;
  logic [7:0]       wave_byte;

  assign wave_pos_inc  = (wave_position == POS_W'(WAVE_STEPS - 1)) ? '0
                                                                   : wave_position + 1'b1;
  assign wave_pos_wide = 7'(wave_pos_inc);
  assign wave_byte     = wave_ram[wave_pos_wide[4:1]];

  // Noise trigger values and shifter feedback
  logic [3:0]  noise_base;
  logic [4:0]  noise_shift;
  logic [15:0] noise_fb;

  assign noise_base  = {1'b0, ctrl_regs[IDX_NR43][2:0]} + 4'd1;
  assign noise_shift = {1'b0, ctrl_regs[IDX_NR43][7:4]} + 5'd1;
  assign noise_fb    = {noise_shifter[14:0],
                        noise_shifter[2] ^ noise_shifter[6] ^
                        noise_shifter[10] ^ noise_shifter[12]};

  logic tick_fire;
  assign tick_fire = (tick_divider == DIV_W'(TICK_DIVIDE - 1));

  // --------------------------------------------------------------------------
  // Next-state logic for one request
  // --------------------------------------------------------------------------
  always_comb begin
    hsc_pkg::pulse_shape_t shape;
    logic [10:0]           pper;
    logic [10:0]           pdec;
    logic [10:0]           wdec;
    logic [19:0]           ndec;

    shape = '0;
    pper  = '0;
    pdec  = '0;
    wdec  = '0;
    ndec  = '0;

    tick_divider_next = tick_divider;
    for (int c = 0; c < 2; c++) begin
      pulse_period_next[c]    = pulse_period[c];
      pulse_count_next[c]     = pulse_count[c];
      pulse_threshold_next[c] = pulse_threshold[c];
      pulse_inverted_next[c]  = pulse_inverted[c];
      pulse_bit_next[c]       = pulse_bit[c];
      pulse_enabled_next[c]   = pulse_enabled[c];
    end
    wave_period_next     = wave_period;
    wave_count_next      = wave_count;
    wave_position_next   = wave_position;
    wave_sample_next     = wave_sample;
    wave_enabled_next    = wave_enabled;
    noise_period_next    = noise_period;
    noise_count_next     = noise_count;
    noise_shifter_next   = noise_shifter;
    noise_bit_next       = noise_bit;
    noise_enabled_next   = noise_enabled;
    noise_remaining_next = noise_remaining;

    res_valid_c = 1'b0;
    res_c       = '0;

    unique case (func)
      hsc_pkg::FUNC_WRITE: begin
        // Pulse triggers: period high bits come from the byte being written
        for (int c = 0; c < 2; c++) begin
          if (address == trig_addr[c] && write_data[7]) begin
            pper  = {write_data[2:0], pulse_lo_reg[c]} ^ hsc_pkg::PERIOD_FLIP;
            shape = hsc_pkg::pulse_shape(pulse_duty_reg[c][7:6], pper);
            pulse_enabled_next[c]   = 1'b1;
            pulse_period_next[c]    = pper;
            pulse_count_next[c]     = pper;
            pulse_threshold_next[c] = shape.threshold;
            pulse_inverted_next[c]  = shape.inverted;
            pulse_bit_next[c]       = shape.inverted;
          end
        end

        if (address == hsc_pkg::A_NR34 && write_data[7]) begin
          wave_period_next   = {write_data[2:0], ctrl_regs[IDX_NR33]} ^
                               hsc_pkg::PERIOD_FLIP;
          wave_count_next    = wave_period_next;
          wave_position_next = '0;
          wave_sample_next   = '0;
          wave_enabled_next  = 1'b1;
        end

        if (address == hsc_pkg::A_NR44) begin
          if (write_data[7]) begin
            noise_period_next    = 20'(noise_base) << noise_shift;
            noise_count_next     = noise_period_next;
            noise_bit_next       = 1'b0;
            noise_enabled_next   = 1'b1;
            // length limit only when bit 6 is set
            noise_remaining_next = write_data[6] ? {~ctrl_regs[IDX_NR41][5:0], 10'd0}
                                                 : 16'd0;
          end else begin
            noise_enabled_next = 1'b0;
          end
        end
      end

      hsc_pkg::FUNC_READ: begin
        res_valid_c     = 1'b1;
        res_c.read_data = hsc_pkg::READ_VALUE;
      end

      hsc_pkg::FUNC_TICK: begin
        tick_divider_next = tick_fire ? '0 : tick_divider + 1'b1;
        if (tick_fire) begin
          // pulse: threshold match wins over the zero reload
          for (int c = 0; c < 2; c++) begin
            if (pulse_enabled[c]) begin
              pdec = pulse_count[c] - 11'd1;
              pulse_count_next[c] = pdec;
              if (pdec == pulse_threshold[c]) begin
                pulse_bit_next[c] = !pulse_inverted[c];
              end else if (pdec == 11'd0) begin
                shape = hsc_pkg::pulse_shape(pulse_duty_reg[c][7:6], pulse_period[c]);
                pulse_count_next[c]     = pulse_period[c];
                pulse_threshold_next[c] = shape.threshold;
                pulse_inverted_next[c]  = shape.inverted;
                pulse_bit_next[c]       = shape.inverted;
              end
            end
          end

          if (wave_enabled) begin
            wdec = wave_count - 11'd1;
            wave_count_next = wdec;
            if (wdec == 11'd0) begin
              wave_position_next = wave_pos_inc;
              // even pointer takes the high nibble
              wave_sample_next   = wave_pos_inc[0] ? wave_byte[3:0] : wave_byte[7:4];
              wave_count_next    = wave_period;
            end
          end

          if (noise_enabled) begin
            ndec = noise_count - 20'd1;
            noise_count_next = ndec;
            if (ndec == 20'd0) begin
              noise_bit_next     = noise_shifter[15];
              noise_shifter_next = noise_fb;
              noise_count_next   = noise_period;
            end
            if (noise_remaining != 16'd0) begin
              noise_remaining_next = noise_remaining - 16'd1;
              if (noise_remaining == 16'd1) begin
                noise_enabled_next = 1'b0;
                noise_bit_next     = 1'b0;
              end
            end
          end

          res_valid_c           = 1'b1;
          res_c.is_sample       = 1'b1;
          res_c.pulse_one_level = pulse_bit_next[0];
          res_c.pulse_two_level = pulse_bit_next[1];
          res_c.wave_level      = wave_sample_next;
          res_c.noise_level     = noise_bit_next;
        end
      end

      default: begin
        // unused code: no effect
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) ctrl_regs[i] <= '0;
      for (int i = 0; i < 16; i++) wave_ram[i] <= '0;
      tick_divider <= '0;
      for (int c = 0; c < 2; c++) begin
        pulse_period[c]    <= '0;
        pulse_count[c]     <= '0;
        pulse_threshold[c] <= '0;
        pulse_inverted[c]  <= 1'b0;
        pulse_bit[c]       <= 1'b0;
        pulse_enabled[c]   <= 1'b0;
      end
      wave_period     <= '0;
      wave_count      <= '0;
      wave_position   <= '0;
      wave_sample     <= '0;
      wave_enabled    <= 1'b0;
      noise_period    <= '0;
      noise_count     <= '0;
      noise_shifter   <= hsc_pkg::NOISE_SEED;
      noise_bit       <= 1'b0;
      noise_enabled   <= 1'b0;
      noise_remaining <= '0;
    end else if (accept) begin
      if (func == hsc_pkg::FUNC_WRITE && in_ctrl) ctrl_regs[ctrl_idx] <= write_data;
      if (func == hsc_pkg::FUNC_WRITE && in_wave) wave_ram[address[3:0]] <= write_data;
      tick_divider <= tick_divider_next;
      for (int c = 0; c < 2; c++) begin
        pulse_period[c]    <= pulse_period_next[c];
        pulse_count[c]     <= pulse_count_next[c];
        pulse_threshold[c] <= pulse_threshold_next[c];
        pulse_inverted[c]  <= pulse_inverted_next[c];
        pulse_bit[c]       <= pulse_bit_next[c];
        pulse_enabled[c]   <= pulse_enabled_next[c];
      end
      wave_period     <= wave_period_next;
      wave_count      <= wave_count_next;
      wave_position   <= wave_position_next;
      wave_sample     <= wave_sample_next;
      wave_enabled    <= wave_enabled_next;
      noise_period    <= noise_period_next;
      noise_count     <= noise_count_next;
      noise_shifter   <= noise_shifter_next;
      noise_bit       <= noise_bit_next;
      noise_enabled   <= noise_enabled_next;
      noise_remaining <= noise_remaining_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register with skid
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_valid_c;
      end
    end else if (accept && res_valid_c) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_res <= skid_valid ? skid_res : res_c;
    end else if (accept && res_valid_c) begin
      skid_res <= res_c;
    end
  end

  assign read_data       = out_res.read_data;
  assign is_sample       = out_res.is_sample;
  assign pulse_one_level = out_res.pulse_one_level;
  assign pulse_two_level = out_res.pulse_two_level;
  assign wave_level      = out_res.wave_level;
  assign noise_level     = out_res.noise_level;

endmodule

`default_nettype wire
